FILE: rtl/mixed_radix_histogram_accumulate_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mixed-radix histogram accumulator.
// They expect signals named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_HISTOGRAM_ACCUMULATE_MACROS_SVH
`define MIXED_RADIX_HISTOGRAM_ACCUMULATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MRHA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrha assertion failed");

// Next-cycle implication, checked outside reset.
`define MRHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrha assertion failed");

`endif

FILE: rtl/mrha_pkg.sv
// ----------------------------------------------------------------------------
// mrha_pkg
// Shared types, constants and codes of the mixed-radix histogram accumulator.
// ----------------------------------------------------------------------------
package mrha_pkg;

	// Sizing of the bin store and of the index datapath.
	localparam int MAX_VARS      = 4;
	localparam int NUM_VALUES    = 4;
	localparam int VAR_LIMIT     = (MAX_VARS < NUM_VALUES) ? MAX_VARS : NUM_VALUES;
	localparam int BIN_ADDR_BITS = 16;
	localparam int BIN_DEPTH     = 1 << BIN_ADDR_BITS;

	// Field widths.
	localparam int VAR_CNT_W  = 3;
	localparam int RADIX_W    = 9;
	localparam int VALUE_W    = 8;
	localparam int WEIGHT_W   = 32;
	localparam int SEL_W      = 16;
	localparam int ADDR_OUT_W = 16;
	localparam int COUNT_W    = 48;
	localparam int SUM_W      = COUNT_W + 1;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int VAL_SEL_W  = $clog2(NUM_VALUES);
	localparam int ACC_W      = RADIX_W + BIN_ADDR_BITS + 1;

	typedef logic [BIN_ADDR_BITS-1:0] bin_addr_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [RADIX_W-1:0] radix_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [NUM_VALUES-1:0][VALUE_W-1:0] value_vec_t;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD        = 2'd0,
		REQ_READ       = 2'd1,
		REQ_READ_CLEAR = 2'd2
	} req_type_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VAR_COUNT = 3'd0,
		REG_RADIX_A   = 3'd1,
		REG_RADIX_B   = 3'd2,
		REG_RADIX_C   = 3'd3,
		REG_RADIX_D   = 3'd4,
		REG_WEIGHT    = 3'd5
	} cfg_reg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_LOOKUP,
		ST_MODIFY,
		ST_DELIVER
	} state_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [VAR_CNT_W-1:0]        var_count;
		logic [NUM_VALUES-1:0][RADIX_W-1:0] radix;
		logic [WEIGHT_W-1:0]         weight;
	} cfg_t;

	// Index unit result.
	typedef struct packed {
		logic      done;
		logic      err;
		bin_addr_t addr;
	} idx_res_t;

endpackage

FILE: rtl/mrha_ram.sv
// ----------------------------------------------------------------------------
// mrha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mrha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/mrha_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrha_cfg_regs
// Configuration registers: variable count, four radices and the add weight.
// ----------------------------------------------------------------------------
module mrha_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mrha_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mrha_pkg::CFG_DATA_W-1:0]  cfg_data,
	output mrha_pkg::cfg_t                   cfg
);

	logic [mrha_pkg::VAR_CNT_W-1:0]                           var_count_q;
	logic [mrha_pkg::NUM_VALUES-1:0][mrha_pkg::RADIX_W-1:0]   radix_q;
	logic [mrha_pkg::WEIGHT_W-1:0]                            weight_q;

	// Register writes; indexes outside the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= '0;
			for (int i = 0; i < mrha_pkg::NUM_VALUES; i++) begin
				radix_q[i] <= mrha_pkg::RADIX_W'(1);
			end
			weight_q <= mrha_pkg::WEIGHT_W'(32'h0001_0000);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mrha_pkg::REG_VAR_COUNT: var_count_q <= cfg_data[mrha_pkg::VAR_CNT_W-1:0];
				mrha_pkg::REG_RADIX_A:   radix_q[0] <= cfg_data[mrha_pkg::RADIX_W-1:0];
				mrha_pkg::REG_RADIX_B:   radix_q[1] <= cfg_data[mrha_pkg::RADIX_W-1:0];
				mrha_pkg::REG_RADIX_C:   radix_q[2] <= cfg_data[mrha_pkg::RADIX_W-1:0];
				mrha_pkg::REG_RADIX_D:   radix_q[3] <= cfg_data[mrha_pkg::RADIX_W-1:0];
				mrha_pkg::REG_WEIGHT:    weight_q <= cfg_data[mrha_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.var_count = var_count_q;
	assign cfg.radix     = radix_q;
	assign cfg.weight    = weight_q;

endmodule

FILE: rtl/mrha_index_unit.sv
// ----------------------------------------------------------------------------
// mrha_index_unit
// Iterative mixed-radix index builder: one multiply-add k = radix*k + value
// per cycle, with range checks on every value and on the growing index.
// ----------------------------------------------------------------------------
module mrha_index_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mrha_pkg::cfg_t       cfg,
	input  mrha_pkg::value_vec_t values,
	output mrha_pkg::idx_res_t   res
);

	logic                           busy_q;
	logic                           done_q;
	logic                           err_q;
	logic                           ovf_q;
	logic [mrha_pkg::VAR_CNT_W-1:0] step_q;
	mrha_pkg::bin_addr_t            k_q;

	mrha_pkg::radix_t               rad;
	mrha_pkg::value_t               val;
	logic [mrha_pkg::ACC_W-1:0]     acc;
	logic                           acc_ovf;
	logic [mrha_pkg::VAR_CNT_W-1:0] step_nxt;
	logic                           no_steps;
	logic                           cnt_bad;

	// One step of the fold for the current variable.
	always_comb begin
		rad      = cfg.radix[step_q[mrha_pkg::VAL_SEL_W-1:0]];
		val      = values[step_q[mrha_pkg::VAL_SEL_W-1:0]];
		acc      = mrha_pkg::ACC_W'(rad) * mrha_pkg::ACC_W'(k_q) + mrha_pkg::ACC_W'(val);
		acc_ovf  = |acc[mrha_pkg::ACC_W-1:mrha_pkg::BIN_ADDR_BITS];
		step_nxt = step_q + mrha_pkg::VAR_CNT_W'(1);
		cnt_bad  = cfg.var_count > mrha_pkg::VAR_CNT_W'(mrha_pkg::VAR_LIMIT);
		no_steps = (cfg.var_count == '0) || cnt_bad;
	end

	// Once the index passes the store it stays past it, so an overflow
	// flag is enough and the low bits may wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			err_q  <= 1'b0;
			ovf_q  <= 1'b0;
			step_q <= '0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				k_q    <= '0;
				ovf_q  <= 1'b0;
				step_q <= '0;
				err_q  <= cnt_bad;
				if (no_steps) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				k_q    <= acc[mrha_pkg::BIN_ADDR_BITS-1:0];
				ovf_q  <= ovf_q | acc_ovf;
				err_q  <= err_q | (mrha_pkg::RADIX_W'(val) >= rad);
				step_q <= step_nxt;
				if (step_nxt == cfg.var_count) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.err  = err_q | ovf_q;
	assign res.addr = k_q;

endmodule

FILE: rtl/mixed_radix_histogram_accumulate.sv
// ----------------------------------------------------------------------------
// mixed_radix_histogram_accumulate
// Histogram over a mixed-radix bin index: add a weight to a bin, read a bin,
// or read and clear a bin, with saturating 48-bit bins in one RAM.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_stall   | req_type, value_a..value_d, bin_select
//   out     | out_valid / out_stall | bin_count, bin_addr, status
//   cfg     | cfg_wr_en             | cfg_index, cfg_data
//
// One item is worked at a time. From accept to the next accept a read passes
// through the lookup, modify and deliver states; an add first passes through the
// multiply-add unit, one step per variable, then the RAM read-modify-write. A
// rejected add skips the RAM, and a var_count above four is rejected at once. A finished
// item waits while out_stall holds the output register. After reset a clearing
// pass zeroes all 2^BIN_ADDR_BITS (65536) bins, one per cycle, with in_stall high.
// ----------------------------------------------------------------------------
module mixed_radix_histogram_accumulate (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mrha_pkg::REQ_W-1:0]        req_type,
	input  logic [mrha_pkg::VALUE_W-1:0]      value_a,
	input  logic [mrha_pkg::VALUE_W-1:0]      value_b,
	input  logic [mrha_pkg::VALUE_W-1:0]      value_c,
	input  logic [mrha_pkg::VALUE_W-1:0]      value_d,
	input  logic [mrha_pkg::SEL_W-1:0]        bin_select,
	// Result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mrha_pkg::COUNT_W-1:0]      bin_count,
	output logic [mrha_pkg::ADDR_OUT_W-1:0]   bin_addr,
	output logic                              status,
	// Configuration writes
	input  logic                              cfg_wr_en,
	input  logic [mrha_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mrha_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mrha_pkg::state_t      state_q;
	mrha_pkg::state_t      state_nxt;
	mrha_pkg::cfg_t        cfg;
	mrha_pkg::idx_res_t    idx_res;

	// Accepted item.
	logic [mrha_pkg::REQ_W-1:0]      req_q;
	mrha_pkg::value_vec_t            values_q;
	logic [mrha_pkg::SEL_W-1:0]      sel_q;
	mrha_pkg::bin_addr_t             addr_q;

	// Clearing pass counter.
	mrha_pkg::bin_addr_t             clr_q;

	// Finished item waiting for the output register.
	mrha_pkg::count_t                res_count_q;
	logic [mrha_pkg::ADDR_OUT_W-1:0] res_addr_q;
	logic                            res_status_q;

	// Output register.
	logic                            out_valid_q;
	mrha_pkg::count_t                out_count_q;
	logic [mrha_pkg::ADDR_OUT_W-1:0] out_addr_q;
	logic                            out_status_q;

	// Control strobes.
	logic                            accept;
	logic                            out_free;
	logic                            idx_start;
	logic                            lk_go;
	logic                            lk_fail;
	logic                            mod_go;
	logic                            deliver;

	// Lookup decisions.
	logic                            sel_oob;
	logic                            lk_err;
	mrha_pkg::bin_addr_t             lk_addr;
	logic [mrha_pkg::ADDR_OUT_W-1:0] lk_rep_addr;

	// RAM ports.
	logic                            mem_wr_en;
	mrha_pkg::bin_addr_t             mem_waddr;
	mrha_pkg::count_t                mem_wdata;
	logic                            mem_rd_en;
	mrha_pkg::count_t                mem_rdata;

	// Modify stage.
	logic [mrha_pkg::SUM_W-1:0]      sum_ext;
	mrha_pkg::count_t                sum_sat;
	mrha_pkg::count_t                mod_count;
	logic                            mod_write;

	mrha_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mrha_index_unit u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (idx_start),
		.cfg    (cfg),
		.values (values_q),
		.res    (idx_res)
	);

	mrha_ram #(
		.WIDTH (mrha_pkg::COUNT_W),
		.DEPTH (mrha_pkg::BIN_DEPTH)
	) u_bins (
		.clk   (clk),
		.wr_en (mem_wr_en),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rd_en (mem_rd_en),
		.raddr (lk_addr),
		.rdata (mem_rdata)
	);

	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = (state_q != mrha_pkg::ST_IDLE);

	// Which bin the lookup touches and whether the request is rejected.
	always_comb begin
		sel_oob     = 32'(sel_q) >= 32'(mrha_pkg::BIN_DEPTH);
		lk_addr     = idx_res.addr;
		lk_err      = 1'b1;
		lk_rep_addr = '0;
		case (req_q)
			mrha_pkg::REQ_ADD: begin
				lk_addr = idx_res.addr;
				lk_err  = idx_res.err;
			end
			mrha_pkg::REQ_READ, mrha_pkg::REQ_READ_CLEAR: begin
				lk_addr     = mrha_pkg::bin_addr_t'(sel_q);
				lk_err      = sel_oob;
				lk_rep_addr = sel_q;
			end
			default: begin
				lk_err = 1'b1;
			end
		endcase
	end

	// Saturating add, or the clear, on the bin just read.
	always_comb begin
		sum_ext   = {1'b0, mem_rdata} + mrha_pkg::SUM_W'(cfg.weight);
		sum_sat   = sum_ext[mrha_pkg::COUNT_W] ? '1 : sum_ext[mrha_pkg::COUNT_W-1:0];
		mod_count = mem_rdata;
		mod_write = 1'b0;
		case (req_q)
			mrha_pkg::REQ_ADD: begin
				mod_count = sum_sat;
				mod_write = 1'b1;
			end
			mrha_pkg::REQ_READ_CLEAR: begin
				mod_write = 1'b1;
			end
			default: begin
				mod_write = 1'b0;
			end
		endcase
	end

	// Next state and control strobes.
	always_comb begin
		state_nxt = state_q;
		idx_start = 1'b0;
		lk_go     = 1'b0;
		lk_fail   = 1'b0;
		mod_go    = 1'b0;
		deliver   = 1'b0;
		mem_rd_en = 1'b0;
		mem_wr_en = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		case (state_q)
			mrha_pkg::ST_CLEAR: begin
				mem_wr_en = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == '1) begin
					state_nxt = mrha_pkg::ST_IDLE;
				end
			end
			mrha_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type == mrha_pkg::REQ_ADD) begin
						idx_start = 1'b1;
						state_nxt = mrha_pkg::ST_INDEX;
					end else begin
						state_nxt = mrha_pkg::ST_LOOKUP;
					end
				end
			end
			mrha_pkg::ST_INDEX: begin
				if (idx_res.done) begin
					state_nxt = mrha_pkg::ST_LOOKUP;
				end
			end
			mrha_pkg::ST_LOOKUP: begin
				if (lk_err) begin
					lk_fail   = 1'b1;
					state_nxt = mrha_pkg::ST_DELIVER;
				end else begin
					lk_go     = 1'b1;
					mem_rd_en = 1'b1;
					state_nxt = mrha_pkg::ST_MODIFY;
				end
			end
			mrha_pkg::ST_MODIFY: begin
				mod_go    = 1'b1;
				mem_wr_en = mod_write;
				mem_wdata = mod_count;
				if (req_q == mrha_pkg::REQ_READ_CLEAR) begin
					mem_wdata = '0;
				end
				state_nxt = mrha_pkg::ST_DELIVER;
			end
			mrha_pkg::ST_DELIVER: begin
				if (out_free) begin
					deliver   = 1'b1;
					state_nxt = mrha_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mrha_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrha_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == mrha_pkg::ST_CLEAR) begin
			clr_q <= clr_q + mrha_pkg::bin_addr_t'(1);
		end
	end

	// Item and result holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q       <= req_type;
			values_q[0] <= value_a;
			values_q[1] <= value_b;
			values_q[2] <= value_c;
			values_q[3] <= value_d;
			sel_q       <= bin_select;
		end
		if (lk_go) begin
			addr_q <= lk_addr;
		end
		if (lk_fail) begin
			res_count_q  <= '0;
			res_addr_q   <= lk_rep_addr;
			res_status_q <= 1'b1;
		end else if (mod_go) begin
			res_count_q  <= mod_count;
			res_addr_q   <= mrha_pkg::ADDR_OUT_W'(addr_q);
			res_status_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			out_count_q  <= res_count_q;
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_count = out_count_q;
	assign bin_addr  = out_addr_q;
	assign status    = out_status_q;

endmodule

FILE: rtl/mrha_checker.sv
// ----------------------------------------------------------------------------
// mrha_checker
// Port-level checks of the histogram accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "mixed_radix_histogram_accumulate_macros.svh"

module mrha_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [mrha_pkg::COUNT_W-1:0]      bin_count,
	input logic                              status
);

	// A stalled result stays offered with the same count.
	`MRHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bin_count))

	// A rejected request never reports a count.
	`MRHA_ASSERT_IMPL(a_err_count_zero, out_valid && status, bin_count == '0)

	// Only one item is worked at a time: an accept closes the input.
	`MRHA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

endmodule

bind mixed_radix_histogram_accumulate mrha_checker u_mrha_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.bin_count (bin_count),
	.status    (status)
);
